>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SWSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define SWSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/swsg_pkg.sv
`default_nettype none

package swsg_pkg;

  // Field widths
  localparam int SegW    = 8;
  localparam int DigitW  = 4;
  localparam int TpcW    = 16;
  localparam int WrapW   = 4;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  // Default tick counter width
  localparam int TickWidthDef = 16;

  // Register reset values
  localparam logic [TpcW-1:0]  TpcReset  = 16'd20;
  localparam logic [WrapW-1:0] WrapReset = 4'd6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegTicksPerCount = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTopWrapValue  = 1'd1;

  localparam logic [DigitW-1:0] DigitNine = 4'd9;

  // Active-low segment codes
  localparam logic [SegW-1:0] SegBlank = 8'hff;

  // Active-low digit strobes by scan position
  localparam logic [SegW-1:0] StrobeTop    = 8'hdf;
  localparam logic [SegW-1:0] StrobeSecond = 8'hef;
  localparam logic [SegW-1:0] StrobeThird  = 8'hf7;
  localparam logic [SegW-1:0] StrobeLast   = 8'hfb;

  typedef struct packed {
    logic start_stop_pressed;
    logic clear_pressed;
  } swsg_in_t;

  typedef struct packed {
    logic [SegW-1:0] segment_pattern;
    logic [SegW-1:0] digit_enable;
    logic            running_flag;
  } swsg_out_t;

  // Decimal digit to active-low segments; values above nine blank.
  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

  function automatic logic [SegW-1:0] strobe_decode(input logic [1:0] pos);
    logic [SegW-1:0] s;
    unique case (pos)
      2'd0:    s = StrobeTop;
      2'd1:    s = StrobeSecond;
      2'd2:    s = StrobeThird;
      default: s = StrobeLast;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stopwatch_with_muxed_seven_segment_core.sv
// Four-digit decimal stopwatch for a multiplexed, active-low 7-segment display.
// Input channel (in_valid/in_stall/in_data): one transaction per display slot,
// carrying debounced start/stop and clear button levels (1 = pressed).
// Output channel (out_valid/out_stall/out_data): one transaction per input,
// giving the segment code and digit strobe of the scanned digit plus the
// running flag. Scan order is top, second, third, last digit.
// Each result is registered in the output register, or in the skid register.
// Throughput: one transaction per cycle unless in_stall; all per-tick work is
// a single pass of logic between the state registers and the output stage.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 = ticks per count,
// index 1 = top digit wrap value; write only while the block is idle.
// Reset (rst_n low, synchronous): digits, run flag, press lock, tick counter
// and scan position go to zero; registers return to 20 and 6.
// Stall: a two-entry output stage (output register plus skid register)
// lets one more transaction in while the receiver stalls; in_stall rises
// only once both entries hold results.
`default_nettype none
`include "assert_macros.svh"

module stopwatch_with_muxed_seven_segment_core #(
  parameter int TICK_WIDTH = swsg_pkg::TickWidthDef
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire swsg_pkg::swsg_in_t          in_data,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      swsg_pkg::swsg_out_t         out_data,
  input  wire logic                        cfg_we,
  input  wire logic [swsg_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [swsg_pkg::CfgDataW-1:0] cfg_wdata
);
  import swsg_pkg::*;

  localparam int CmpW = (TICK_WIDTH > TpcW) ? TICK_WIDTH : TpcW;

  // Configuration registers
  logic [TpcW-1:0]  tpc_r;
  logic [WrapW-1:0] wrap_r;

  // Stopwatch state
  logic [DigitW-1:0]     top_r, sec_r, thd_r, lst_r;
  logic [DigitW-1:0]     top_nxt, sec_nxt, thd_nxt, lst_nxt;
  logic                  run_r, run_nxt;
  logic                  lock_r, lock_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [1:0]            pos_r, pos_nxt;

  // Output stage
  swsg_out_t out_data_r, skid_data_r, res;
  logic      out_valid_r, skid_valid_r;

  logic                  in_fire;
  logic [DigitW-1:0]     top_c, sec_c, thd_c, lst_c;
  logic [DigitW-1:0]     top_a, sec_a, thd_a, lst_a;
  logic [TICK_WIDTH-1:0] tick_c;
  logic                  adv;
  logic [DigitW-1:0]     shown;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpc_r  <= TpcReset;
      wrap_r <= WrapReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTicksPerCount: tpc_r  <= cfg_wdata[TpcW-1:0];
        RegTopWrapValue:  wrap_r <= cfg_wdata[WrapW-1:0];
        default:          ;
      endcase
    end
  end

  // Per-tick update: clear, start/stop, count advance, display, counters
  always_comb begin
    // clear
    top_c  = in_data.clear_pressed ? '0 : top_r;
    sec_c  = in_data.clear_pressed ? '0 : sec_r;
    thd_c  = in_data.clear_pressed ? '0 : thd_r;
    lst_c  = in_data.clear_pressed ? '0 : lst_r;
    tick_c = in_data.clear_pressed ? '0 : tick_r;

    // start/stop with release lock
    run_nxt  = run_r;
    lock_nxt = lock_r;
    if (in_data.start_stop_pressed && !lock_r) begin
      lock_nxt = 1'b1;
      run_nxt  = !run_r;
    end
    if (!in_data.start_stop_pressed) begin
      lock_nxt = 1'b0;
    end

    adv = run_nxt && (CmpW'(tick_c) >= CmpW'(tpc_r));

    // decimal increment with ripple through nines; all digits go to zero
    // whenever the top digit would then equal the wrap value
    top_a = top_c;
    sec_a = sec_c;
    thd_a = thd_c;
    lst_a = lst_c;
    if (lst_c != DigitNine) begin
      lst_a = lst_c + 4'd1;
    end else if (thd_c != DigitNine) begin
      lst_a = '0;
      thd_a = thd_c + 4'd1;
    end else if (sec_c != DigitNine) begin
      lst_a = '0;
      thd_a = '0;
      sec_a = sec_c + 4'd1;
    end else if (top_c != wrap_r) begin
      lst_a = '0;
      thd_a = '0;
      sec_a = '0;
      top_a = top_c + 4'd1;
    end
    if (top_a == wrap_r) begin
      top_a = '0;
      sec_a = '0;
      thd_a = '0;
      lst_a = '0;
    end

    top_nxt = adv ? top_a : top_c;
    sec_nxt = adv ? sec_a : sec_c;
    thd_nxt = adv ? thd_a : thd_c;
    lst_nxt = adv ? lst_a : lst_c;

    // scanned digit
    unique case (pos_r)
      2'd0:    shown = top_nxt;
      2'd1:    shown = sec_nxt;
      2'd2:    shown = thd_nxt;
      default: shown = lst_nxt;
    endcase
    res.segment_pattern = seg_decode(shown);
    res.digit_enable    = strobe_decode(pos_r);
    res.running_flag    = run_nxt;

    // saturating tick counter, restarted by an advance
    if (adv) begin
      tick_nxt = TICK_WIDTH'(1);
    end else if (tick_c != '1) begin
      tick_nxt = tick_c + TICK_WIDTH'(1);
    end else begin
      tick_nxt = tick_c;
    end
    pos_nxt = pos_r + 2'd1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      sec_r  <= '0;
      thd_r  <= '0;
      lst_r  <= '0;
      run_r  <= 1'b0;
      lock_r <= 1'b0;
      tick_r <= '0;
      pos_r  <= '0;
    end else if (in_fire) begin
      top_r  <= top_nxt;
      sec_r  <= sec_nxt;
      thd_r  <= thd_nxt;
      lst_r  <= lst_nxt;
      run_r  <= run_nxt;
      lock_r <= lock_nxt;
      tick_r <= tick_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        // no new transaction while the skid entry is full
        if (!out_stall) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_r && out_stall) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && out_stall) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  // Checks
  `SWSG_ASSERT_NOW(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r)
  `SWSG_ASSERT_NEXT(a_clear_restarts_tick, clk, rst_n,
    in_fire && in_data.clear_pressed, tick_r == TICK_WIDTH'(1))
  `SWSG_ASSERT_NEXT(a_run_holds_idle, clk, rst_n, !in_fire, $stable(run_r))
  `SWSG_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_r)

endmodule

`default_nettype wire
